// ===== rtl/asfr_pkg.sv =====
// Package for the ADC scale / filter / ramp block: beat structs, constants.
// No dependencies; imported by every module under rtl/.
package asfr_pkg;

   localparam int CH_W        = 3;
   localparam int LEVEL_W     = 12;
   localparam int PCT_W       = 7;
   localparam int SUM_W       = 16;
   localparam int REF_COUNT   = 7;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 3'd7;
   localparam logic [CH_W-1:0]      CH_ONE       = 3'd1;

   localparam logic [LEVEL_W-1:0] REF_RESET   = 12'd330;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 12'd4095;
   localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
   localparam int                 RAMP_LEVELS = 19;
   localparam int                 RAMP_STEP   = 5;

   // n/10 == (n * 0xCCCD) >> 19 for every 16-bit n
   localparam logic [SUM_W-1:0] RECIP_TEN   = 16'hCCCD;
   localparam int               RECIP_SHIFT = 19;

   typedef logic [REF_COUNT-1:0][LEVEL_W-1:0] ref_bank_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [LEVEL_W-1:0] raw_sample;
      logic               running;
   } req_beat_type;

   typedef struct packed {
      logic [CH_W-1:0]    out_channel;
      logic [LEVEL_W-1:0] filtered_level;
      logic               release_pulse;
      logic [PCT_W-1:0]   percent_level;
      logic               percent_changed;
   } rsp_beat_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic               ch_ok;
      logic [LEVEL_W-1:0] level;
      logic               running;
   } scaled_beat_type;

endpackage

// ===== rtl/adc_scale_filter_ramp_top.sv =====
// Path: a req beat is registered in the input, scaled and result stages in turn.
// Throughput: one beat per cycle while rsp is not stalled, through three register
// stages (input, scaled, result), each with its own valid, so bubbles collapse;
// a waiting result lets at most two more req beats in before req_stall rises.
// Synchronous active-high reset clears valids, filter memory and percentage;
// refs 330, setpoint 0.
module adc_scale_filter_ramp_top
   import asfr_pkg::*;
#(
   parameter int NUM_CHANNELS = 7,
   parameter int ADC_BITS     = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   // sample channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_beat_type         req_beat,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_beat_type         rsp_beat,
   // register writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEVEL_W-1:0]   csr_wdata
);

   // reference scales, one per channel, and the release threshold
   ref_bank_type       ref_ff;
   logic [LEVEL_W-1:0] setpoint_ff;

   logic            req_ready;
   logic            mid_valid, mid_ready;
   scaled_beat_type mid_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REF_COUNT; i++) begin
            ref_ff[i] <= REF_RESET;
         end
         setpoint_ff <= '0;
      end else if (csr_wr_en) begin
         // indexes past the setpoint fall through and are dropped
         if (int'(csr_index) < REF_COUNT) begin
            ref_ff[csr_index] <= csr_wdata;
         end else if (csr_index == CSR_SETPOINT) begin
            setpoint_ff <= csr_wdata;
         end
      end
   end

   assign req_stall = !req_ready;

   // stages 1 and 2: capture the beat, then multiply by the channel's reference
   asfr_scale #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .ADC_BITS     (ADC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_beat   (req_beat),
      .ref_bank  (ref_ff),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_beat  (mid_beat)
   );

   // stage 3: filter memory read-modify-write and ramp update happen at the
   // same edge that loads the result, so a following beat on the same
   // channel always sees the fresh value
   asfr_filter #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_beat   (mid_beat),
      .setpoint  (setpoint_ff),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_beat  (rsp_beat)
   );

`ifndef SYNTHESIS
   // nothing is left in flight after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   // the ramp only moves on channel one and never past the level plus one step
   a_ramp_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beat.percent_changed) |->
         (rsp_beat.out_channel == CH_ONE) &&
         ({6'b0, rsp_beat.percent_level} <=
          {1'b0, rsp_beat.filtered_level} + 13'(RAMP_STEP)))
      else $error("percentage change out of bounds");

   // release only for channel one
   a_release_ch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beat.release_pulse) |-> (rsp_beat.out_channel == CH_ONE))
      else $error("release on wrong channel");

   // channels without a filter report zero and raise no flag
   a_bad_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((int'(rsp_beat.out_channel) >= NUM_CHANNELS) ||
                     (int'(rsp_beat.out_channel) >= REF_COUNT))) |->
         (rsp_beat.filtered_level == '0) && !rsp_beat.release_pulse &&
         !rsp_beat.percent_changed)
      else $error("unfiltered channel produced data");
`endif

endmodule

// ===== rtl/asfr_scale.sv =====
// Input register and reference scaling stage: raw * ref >> ADC_BITS, saturated.
// Depends on asfr_pkg.
module asfr_scale
   import asfr_pkg::*;
#(
   parameter int NUM_CHANNELS = 7,
   parameter int ADC_BITS     = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_beat_type    in_beat,
   input  ref_bank_type    ref_bank,
   output logic            out_valid,
   input  logic            out_ready,
   output scaled_beat_type out_beat
);

   localparam int PROD_W = 2 * LEVEL_W;

   logic            s1_valid_ff, s1_valid_in;
   req_beat_type    s1_beat_ff;
   logic            s2_valid_ff, s2_valid_in;
   scaled_beat_type s2_beat_ff, s2_beat_in;
   logic            s1_ready, s2_ready;
   logic            ch_ok;
   logic [LEVEL_W-1:0] ref_sel;
   logic [PROD_W-1:0]  prod, shifted;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      ch_ok   = (int'(s1_beat_ff.channel) < NUM_CHANNELS) &&
                (int'(s1_beat_ff.channel) < REF_COUNT);
      ref_sel = ch_ok ? ref_bank[s1_beat_ff.channel] : '0;
      prod    = {{LEVEL_W{1'b0}}, s1_beat_ff.raw_sample} * {{LEVEL_W{1'b0}}, ref_sel};
      shifted = prod >> ADC_BITS;
      s2_beat_in.channel = s1_beat_ff.channel;
      s2_beat_in.ch_ok   = ch_ok;
      s2_beat_in.running = s1_beat_ff.running;
      s2_beat_in.level   = (|shifted[PROD_W-1:LEVEL_W]) ? LEVEL_MAX : shifted[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_beat_ff <= in_beat;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_beat_ff <= s2_beat_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_beat  = s2_beat_ff;

endmodule

// ===== rtl/asfr_filter.sv =====
// Per-channel low-pass filter, release detect, conduction ramp, result register.
// Depends on asfr_pkg.
module asfr_filter
   import asfr_pkg::*;
#(
   parameter int NUM_CHANNELS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  scaled_beat_type    in_beat,
   input  logic [LEVEL_W-1:0] setpoint,
   output logic               out_valid,
   input  logic               out_stall,
   output rsp_beat_type       out_beat
);

   localparam int FILT_DEPTH = (NUM_CHANNELS < REF_COUNT) ? NUM_CHANNELS : REF_COUNT;
   localparam int IDX_W      = (FILT_DEPTH > 1) ? $clog2(FILT_DEPTH) : 1;
   localparam int QPROD_W    = 2 * SUM_W;

   logic [LEVEL_W-1:0] mem_ff [FILT_DEPTH];
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic               out_valid_ff, out_valid_in;
   rsp_beat_type       out_beat_ff, out_beat_in;

   logic               fire;
   logic [IDX_W-1:0]   idx;
   logic [LEVEL_W-1:0] last, level;
   logic [SUM_W-1:0]   sum;
   logic [QPROD_W-1:0] qprod;
   logic [QPROD_W-RECIP_SHIFT-1:0] quot;
   logic               ramp_en, release_hit, changed;
   logic [RAMP_LEVELS-1:0] hit;

   assign in_ready     = !out_valid_ff || !out_stall;
   assign fire         = in_valid && in_ready;
   assign out_valid_in = in_ready ? in_valid : out_valid_ff;
   assign idx          = in_beat.channel[IDX_W-1:0];

   always_comb begin
      last  = in_beat.ch_ok ? mem_ff[idx] : '0;
      sum   = SUM_W'(in_beat.level) + {1'b0, last, 3'b000} + SUM_W'(last);
      qprod = {{SUM_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP_TEN};
      quot  = qprod[QPROD_W-1:RECIP_SHIFT];
      if (!in_beat.ch_ok) begin
         level = '0;
      end else if (|quot[QPROD_W-RECIP_SHIFT-1:LEVEL_W]) begin
         level = LEVEL_MAX;
      end else begin
         level = quot[LEVEL_W-1:0];
      end

      ramp_en     = in_beat.ch_ok && in_beat.running && (in_beat.channel == CH_ONE);
      release_hit = ramp_en && (level >= setpoint);

      // first table level at or above the percentage that the level meets
      for (int j = 0; j < RAMP_LEVELS; j++) begin
         hit[j] = (level >= LEVEL_W'(RAMP_STEP * (j + 1))) &&
                  (pct_ff <= PCT_W'(RAMP_STEP * (j + 1)));
      end
      pct_in  = pct_ff;
      changed = 1'b0;
      if (ramp_en && (pct_ff < PCT_FULL)) begin
         for (int j = RAMP_LEVELS - 1; j >= 0; j--) begin
            if (hit[j]) begin
               pct_in  = PCT_W'(RAMP_STEP * (j + 2));
               changed = 1'b1;
            end
         end
      end

      out_beat_in.out_channel     = in_beat.channel;
      out_beat_in.filtered_level  = level;
      out_beat_in.release_pulse   = release_hit;
      out_beat_in.percent_level   = pct_in;
      out_beat_in.percent_changed = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pct_ff       <= '0;
         for (int i = 0; i < FILT_DEPTH; i++) begin
            mem_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            pct_ff <= pct_in;
            if (in_beat.ch_ok) begin
               mem_ff[idx] <= level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_beat_ff <= out_beat_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

endmodule

// ===== test/adc_scale_filter_ramp_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for adc_scale_filter_ramp_top: directed and random sample beats checked
// against a local scale / filter / ramp predictor. Depends on rtl/asfr_pkg.sv and the top.
module adc_scale_filter_ramp_top_tb;
   import asfr_pkg::*;

   localparam int LATENCY        = 2;     // req accept edge to rsp edge
   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat moving
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_BEATS    = 200;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_beat_type         req_beat;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_beat_type         rsp_beat;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEVEL_W-1:0]   csr_wdata;

   adc_scale_filter_ramp_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block's registers and state, updated as beats are accepted.
   logic [LEVEL_W-1:0] ref_reg [REF_COUNT];
   logic [LEVEL_W-1:0] setpoint_reg;
   logic [LEVEL_W-1:0] filter_mem [REF_COUNT];
   logic [PCT_W-1:0]   conduction_pct;

   rsp_beat_type levels_due[$];   // predicted rsp beats, oldest first

   int gap_max;      // sender idle draw, 0..gap_max cycles per beat
   int stall_max;    // receiver stall draw, 0..stall_max cycles per beat
   int stall_left;
   int idle_cycles;
   int fail_count;
   int samples_sent;
   int results_seen;
   int release_count;
   int ignored_count;
   int settings_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Scale by the channel's reference, low-pass as floor((x + 9*last)/10), then
   // handle the channel 1 release compare and conduction ramp. Updates the shadow.
   function automatic rsp_beat_type scale_filter_ramp(input req_beat_type beat);
      rsp_beat_type        res;
      logic [23:0]         product;
      logic [LEVEL_W-1:0]  scaled;
      logic [15:0]         sum;
      int                  lv;
      bit                  stepped;
      res = '0;
      res.out_channel = beat.channel;
      // channel 7 has no reference register: no state change at all
      if (beat.channel < REF_COUNT) begin
         product = 24'(beat.raw_sample) * 24'(ref_reg[beat.channel]);
         scaled  = product[23:12];
         sum     = 16'(scaled) + 16'd9 * 16'(filter_mem[beat.channel]);
         res.filtered_level = LEVEL_W'(sum / 16'd10);
         filter_mem[beat.channel] = res.filtered_level;
         if (beat.channel == CH_ONE && beat.running) begin
            res.release_pulse = (res.filtered_level >= setpoint_reg);
            // ramp one table level at most; stuck once full
            if (conduction_pct < PCT_FULL) begin
               stepped = 1'b0;
               for (int j = 1; j <= RAMP_LEVELS; j++) begin
                  lv = RAMP_STEP * j;
                  if (!stepped && res.filtered_level >= lv && conduction_pct <= lv) begin
                     conduction_pct = PCT_W'(lv + RAMP_STEP);
                     res.percent_changed = 1'b1;
                     stepped = 1'b1;
                  end
               end
            end
         end
      end else begin
         ignored_count++;
      end
      res.percent_level = conduction_pct;
      if (res.release_pulse) release_count++;
      return res;
   endfunction

   task automatic compare_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   // Sampling at the rising edge: check the rsp beat first, then predict the
   // req beat taken at the same edge, so ordering inside the step never matters.
   always @(posedge clock) begin
      rsp_beat_type expected;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            results_seen++;
            stall_left = $urandom_range(0, stall_max);
            if (levels_due.size() == 0) begin
               $error("rsp beat with no sample pending: %p", rsp_beat);
               fail_count++;
            end else begin
               expected = levels_due.pop_front();
               compare_field("out_channel", expected.out_channel, rsp_beat.out_channel);
               compare_field("filtered_level", expected.filtered_level,
                             rsp_beat.filtered_level);
               compare_field("release_pulse", expected.release_pulse, rsp_beat.release_pulse);
               compare_field("percent_level", expected.percent_level, rsp_beat.percent_level);
               compare_field("percent_changed", expected.percent_changed,
                             rsp_beat.percent_changed);
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            levels_due.push_back(scale_filter_ramp(req_beat));
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Receiver back-pressure: stall for the drawn count after each rsp beat.
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One req beat after a random gap; returns at the edge that took it.
   task automatic send_sample(input req_beat_type beat);
      int gap;
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_beat  <= beat;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic send_fields(input int ch, input int raw, input bit run);
      req_beat_type beat;
      beat.channel    = CH_W'(ch);
      beat.raw_sample = LEVEL_W'(raw);
      beat.running    = run;
      send_sample(beat);
   endtask

   // Sender holds off until every predicted beat has come back, plus the pipe.
   task automatic wait_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   // Write all seven references and the setpoint; ref_value < 0 draws each one.
   task automatic load_config(input int ref_value, input int setpoint);
      logic [LEVEL_W-1:0] value;
      for (int i = 0; i < REF_COUNT; i++) begin
         value = (ref_value < 0) ? LEVEL_W'($urandom) : LEVEL_W'(ref_value);
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= value;
         ref_reg[i] = value;
      end
      @(negedge clock);
      csr_wr_en    <= 1'b1;
      csr_index    <= CSR_SETPOINT;
      csr_wdata    <= LEVEL_W'(setpoint);
      setpoint_reg  = LEVEL_W'(setpoint);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   // Field extremes on every channel, including the one without a filter.
   // Channel 1 is sent not running so the ramp stays at zero here.
   task automatic test_field_extremes;
      for (int ch = 0; ch <= 7; ch++)
         send_fields(ch, 4095, ch != CH_ONE);
      send_fields(0, 0, 1'b1);
      send_fields(6, 0, 1'b0);
      wait_drained;
   endtask

   // Full-scale channel 1, running but for the sixth beat: level climbs through
   // the setpoint so release goes 0 then 1; the percentage steps once per running beat.
   task automatic test_ramp_and_release;
      load_config(4095, 1500);
      for (int i = 0; i < 12; i++)
         send_fields(CH_ONE, 4095, i != 5);
      wait_drained;
   endtask

   function automatic req_beat_type random_sample;
      req_beat_type beat;
      int           pick;
      pick = $urandom_range(0, 99);
      // channel 1 is where release and ramp live, so weight it up
      if (pick < 40)
         beat.channel = CH_ONE;
      else if (pick < 46)
         beat.channel = CH_W'(REF_COUNT);
      else
         beat.channel = CH_W'($urandom_range(0, REF_COUNT - 1));
      pick = $urandom_range(0, 9);
      if (pick == 0)
         beat.raw_sample = '0;
      else if (pick == 1)
         beat.raw_sample = LEVEL_MAX;
      else
         beat.raw_sample = LEVEL_W'($urandom);
      beat.running = ($urandom_range(0, 3) != 0);
      return beat;
   endfunction

   // Several register settings, the extremes among them, each with its own
   // idle/stall mix; one phase runs with no gaps and no stalls at all.
   task automatic test_random_phases;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         unique case (p)
            0: begin load_config(4095, 4095); gap_max = 8; stall_max = 8; end
            1: begin load_config(0, 0);       gap_max = 0; stall_max = 0; end
            2: begin load_config(-1, $urandom_range(0, 4095)); gap_max = 0; stall_max = 8; end
            3: begin load_config(-1, $urandom_range(1000, 3000)); gap_max = 8; stall_max = 0; end
            default: begin load_config(330, $urandom_range(0, 400)); gap_max = 4; stall_max = 4; end
         endcase
         for (int i = 0; i < PHASE_BEATS; i++) begin
            send_sample(random_sample());
            if ($urandom_range(0, 49) == 0) wait_drained;
         end
         wait_drained;
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_beat    <= '0;
      rsp_stall   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      gap_max      = 8;
      stall_max    = 8;
      stall_left   = 0;
      idle_cycles  = 0;
      fail_count   = 0;
      samples_sent = 0;
      results_seen = 0;
      release_count  = 0;
      ignored_count  = 0;
      settings_count = 0;
      for (int i = 0; i < REF_COUNT; i++) begin
         ref_reg[i]    = REF_RESET;
         filter_mem[i] = '0;
      end
      setpoint_reg   = '0;
      conduction_pct = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes;
      test_ramp_and_release;
      test_random_phases;
      wait_drained;

      $display("%0d samples over %0d register settings, %0d results checked",
               samples_sent, settings_count + 1, results_seen);
      $display("%0d release pulses, %0d ignored-channel beats, final conduction %0d%%",
               release_count, ignored_count, conduction_pct);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
